FILE: rtl/core/scd_pkg.sv
package scd_pkg;

    localparam int SEED_WORDS = 8;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FINISH = 2'd1,
        OP_MIX = 2'd2,
        OP_GEN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MSG_SEED = 2'd0,
        MSG_MIX = 2'd1,
        MSG_BLK = 2'd2,
        MSG_STATE = 2'd3
    } msg_t;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_READ, ST_HASH, ST_OUT
    } st_t;

    // request from sequencer to round unit
    typedef struct packed {
        logic         start;
        logic         first;
        logic [511:0] block;
    } cmp_req_t;

    typedef struct packed {
        logic         done;
        logic [255:0] digest;
    } cmp_rsp_t;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[56 - 8*i +: 8];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/scd_ram.sv
module scd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/scd_round.sv
// One SHA-256 round per cycle, 16-word schedule window.
module scd_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  scd_pkg::cmp_req_t req,
    output scd_pkg::cmp_rsp_t rsp
);
    import scd_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [255:0] h_reg;
    logic [5:0] rnd_reg;
    logic busy_reg, done_reg;
    logic [31:0] s0, s1, wn, e1, ch, a0, mj, t1, t2;

    always_comb begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        e1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + e1 + ch + round_k(rnd_reg) + w_reg[0];
        a0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = a0 + mj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                h_reg    <= req.first ? SHA_IV : h_reg;
                for (int i = 0; i < 16; i++) begin
                    w_reg[i] <= req.block[511 - 32*i -: 32];
                end
                for (int i = 0; i < 8; i++) begin
                    v_reg[i] <= req.first ? SHA_IV[255 - 32*i -: 32]
                                          : h_reg[255 - 32*i -: 32];
                end
            end else if (busy_reg) begin
                for (int i = 0; i < 15; i++) begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wn;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    for (int i = 0; i < 8; i++) begin
                        h_reg[255 - 32*i -: 32] <= h_reg[255 - 32*i -: 32] + (i == 0 ?
                            t1 + t2 : i == 4 ? v_reg[3] + t1 : v_reg[(i + 7) % 8]);
                    end
                end
            end
        end
    end

    assign rsp = {done_reg, h_reg};
endmodule

FILE: rtl/core/sha256_counter_drbg.sv
// SHA-256 counter DRBG.
// Per input transaction: load writes one seed buffer word; mix runs one compression;
// finish runs a buffer sweep and two compressions; generate runs three compressions,
// then one word per cycle while m_tready is high; unseeded or zero-count requests skip
// hashing. One request at a time; each compression runs on the single round unit.
// Reset (aresetn low, synchronous) clears state, counter, seeded flag; the seed
// buffer memory is then cleared by a pass over all its words before the first transaction.
module sha256_counter_drbg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], word_index[4:2], data_word[68:5], byte_count[74:69]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // random_word[63:0]
    output logic [63:0] m_tdata,
    // status
    output logic        m_tuser,
    output logic        m_tlast
);
    import scd_pkg::*;

    localparam int AW = $clog2(SEED_WORDS);

    st_t st_reg, st_next;
    logic [255:0] state_reg, block_reg;
    logic [63:0] cnt_reg, data_reg;
    logic seeded_reg;
    logic [1:0] op_reg;
    logic [5:0] bc_reg;
    logic [AW:0] ptr_reg;
    logic [511:0] seed_reg;
    msg_t msg_reg;
    logic second_reg;
    logic [1:0] wi_reg, nw_reg;
    logic status_reg;
    logic kick_reg;

    logic ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [63:0] ram_wd, ram_rd;
    cmp_req_t req;
    cmp_rsp_t rsp;

    scd_ram #(.WIDTH(64), .DEPTH(SEED_WORDS)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_rd));

    scd_round u_round (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    logic [1:0] in_op;
    logic [5:0] in_bc;
    assign in_op = s_tdata[1:0];
    assign in_bc = s_tdata[74:69];

    assign s_tready = (st_reg == ST_IDLE);

    // memory port steering: clear pass, seed loads, finish sweep
    always_comb begin
        ram_we = 1'b0;
        ram_wa = ptr_reg[AW-1:0];
        ram_wd = '0;
        ram_ra = ptr_reg[AW-1:0];
        if (st_reg == ST_CLR) begin
            ram_we = 1'b1;
        end else if (st_reg == ST_IDLE && s_tvalid && in_op == OP_LOAD) begin
            ram_we = 1'b1;
            ram_wa = s_tdata[2+AW-1:2];
            ram_wd = s_tdata[68:5];
        end else if (st_reg == ST_READ && op_reg == OP_FINISH) begin
            ram_we = (ptr_reg != '0);
            ram_wa = ptr_reg[AW-1:0] - AW'(1);
        end
    end

    // message block for the round unit
    always_comb begin
        req.start = kick_reg;
        req.first = !second_reg;
        req.block = '0;
        case (msg_reg)
            MSG_SEED: req.block = second_reg ? {1'b1, 447'd0, 64'd512} : seed_reg;
            MSG_MIX:  req.block = {state_reg, data_reg[31:0], 8'h80, 152'd0, 64'd288};
            MSG_BLK:  req.block = {state_reg, bswap64(cnt_reg), 8'h80, 120'd0, 64'd320};
            MSG_STATE: req.block = second_reg ?
                           {bswap64(cnt_reg), 8'h80, 376'd0, 64'd576}
                         : {state_reg, block_reg};
            default: req.block = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            state_reg <= '0;
            cnt_reg <= '0;
            seeded_reg <= 1'b0;
            ptr_reg <= '0;
        end else begin
            st_reg <= st_next;
            case (st_reg)
                ST_CLR: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == (AW+1)'(SEED_WORDS - 1)) ptr_reg <= '0;
                end
                ST_IDLE: if (s_tvalid) begin
                    op_reg <= in_op;
                    data_reg <= s_tdata[68:5];
                    bc_reg <= (in_bc > 6'd32) ? 6'd32 : in_bc;
                    nw_reg <= 2'(((in_bc > 6'd32 ? 6'd32 : in_bc) - 6'd1) >> 3);
                    wi_reg <= '0;
                    ptr_reg <= '0;
                    second_reg <= 1'b0;
                    status_reg <= (in_op[1] && !seeded_reg);
                    msg_reg <= (in_op == OP_MIX) ? MSG_MIX : (in_op == OP_GEN) ? MSG_BLK
                                                                           : MSG_SEED;
                end
                ST_READ: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg != '0)
                        seed_reg[511 - 64*(32'(ptr_reg) - 1) -: 64] <= ram_rd;
                end
                ST_HASH: if (rsp.done) begin
                    case (msg_reg)
                        MSG_SEED: if (second_reg) begin
                            state_reg <= rsp.digest;
                            cnt_reg <= data_reg;
                            seeded_reg <= 1'b1;
                        end
                        MSG_MIX: state_reg <= rsp.digest;
                        MSG_BLK: begin
                            block_reg <= rsp.digest;
                            msg_reg <= MSG_STATE;
                        end
                        MSG_STATE: if (second_reg) begin
                            state_reg <= rsp.digest;
                            cnt_reg <= cnt_reg + 64'd1;
                        end
                        default: ;
                    endcase
                    second_reg <= !second_reg && (msg_reg == MSG_SEED ||
                                                  msg_reg == MSG_STATE);
                    if (msg_reg == MSG_BLK) second_reg <= 1'b0;
                end
                ST_OUT: if (m_tready) wi_reg <= wi_reg + 2'd1;
                default: ;
            endcase
        end
    end

    logic gen_ok;
    assign gen_ok = (op_reg == OP_GEN) && seeded_reg && bc_reg != 6'd0;

    // next state; round unit kicked on entry to hashing and again between compressions
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_CLR: if (ptr_reg == (AW+1)'(SEED_WORDS - 1)) st_next = ST_IDLE;
            ST_IDLE: if (s_tvalid) begin
                st_next = (in_op == OP_FINISH) ? ST_READ :
                          (in_op == OP_LOAD) ? ST_OUT :
                          (!seeded_reg || (in_op == OP_GEN && in_bc == 6'd0)) ? ST_OUT
                                                                             : ST_HASH;
            end
            ST_READ: if (ptr_reg == (AW+1)'(SEED_WORDS)) st_next = ST_HASH;
            ST_HASH: if (rsp.done) begin
                if ((msg_reg == MSG_SEED && second_reg) || msg_reg == MSG_MIX ||
                    (msg_reg == MSG_STATE && second_reg))
                    st_next = ST_OUT;
            end
            ST_OUT: if (m_tready && (!gen_ok || wi_reg == nw_reg)) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_reg <= 1'b0;
        end else begin
            kick_reg <= (st_next == ST_HASH) &&
                        (st_reg != ST_HASH || (rsp.done && st_reg == ST_HASH));
        end
    end

    // result word with bytes past the count zeroed
    logic [63:0] word;
    always_comb begin
        word = '0;
        for (int j = 0; j < 8; j++) begin
            if (6'(8*wi_reg + j) < bc_reg)
                word[63 - 8*j -: 8] = block_reg[255 - 64*wi_reg - 8*j -: 8];
        end
    end

    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = gen_ok ? word : 64'd0;
    assign m_tuser  = status_reg;
    assign m_tlast  = !gen_ok || (wi_reg == nw_reg);
endmodule
